@@ hdl/pse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and functions of the stored-deflate PNG encoder.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] REG_WIDTH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'b1;

  // largest stored image size
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [25:0] BLOCK_MAX = 26'd65535;

  // kinds of output byte
  typedef enum logic [3:0] {
    K_PRE,      // signature, IHDR, IDAT length and type, zlib header
    K_BHDR,     // stored block header byte
    K_FILT,     // filter byte
    K_PIX,      // pixel byte
    K_ADLER,    // adler-32 bytes
    K_DCRC,     // idat crc bytes
    K_TAIL      // IEND chunk
  } kind_e;

  // one queued item from the front part
  typedef struct packed {
    logic [7:0] px;
    logic       first;    // image start: emit preamble
    logic       filt;     // row starts: filter byte
    logic       endimg;   // last raw byte of the image
  } job_t;

  // one step of the bit-serial CRC-32, eight bits in one call
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  // fixed tail bytes: length 0, "IEND", crc of IEND
  function automatic logic [7:0] tail_byte(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0, 4'd1, 4'd2, 4'd3: r = 8'h00;
      4'd4: r = 8'h49;
      4'd5: r = 8'h45;
      4'd6: r = 8'h4E;
      4'd7: r = 8'h44;
      4'd8: r = 8'hAE;
      4'd9: r = 8'h42;
      4'd10: r = 8'h60;
      4'd11: r = 8'h82;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/pse_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_front
// Accepts pixel bytes, tracks row and image position, queues classified items.
// ----------------------------------------------------------------------------
module pse_front #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [7:0]      pixel_byte_i,
  input  logic [12:0]     width_i,
  input  logic [12:0]     height_i,
  output logic            idle_o,
  input  logic            deq_i,
  output logic            qvalid_o,
  output pse_pkg::job_t   job_o
);
  import pse_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);

  logic          started_q;
  logic [14:0]   col_q;    // raw bytes of the current row seen, filter excluded
  logic [12:0]   row_q;
  job_t          mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic          acc;
  job_t          nj;
  logic          row_end;

  assign full_o   = (cnt_q == (PtrW+1)'(Depth));
  assign acc      = push_i && !full_o;
  assign qvalid_o = (cnt_q != '0);
  assign job_o    = mem_q[rp_q];
  assign idle_o   = !started_q && (cnt_q == '0);

  // classify the incoming byte
  assign row_end = (col_q + 15'd1 == 15'd3 * {2'd0, width_i});
  always_comb begin
    nj.px     = pixel_byte_i;
    nj.first  = !started_q;
    nj.filt   = (col_q == '0);
    nj.endimg = row_end && (row_q + 13'd1 == height_i);
  end

  // position tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
    end else if (acc) begin
      if (nj.endimg) begin
        started_q <= 1'b0;
        col_q     <= '0;
        row_q     <= '0;
      end else begin
        started_q <= 1'b1;
        if (row_end) begin
          col_q <= '0;
          row_q <= row_q + 13'd1;
        end else begin
          col_q <= col_q + 15'd1;
        end
      end
    end
  end

  // item queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (acc) wp_q <= wp_q + PtrW'(1);
      if (deq_i) rp_q <= rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(acc) - (PtrW+1)'(deq_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) mem_q[wp_q] <= nj;
  end

endmodule

@@ hdl/pse_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_back
// Sequences each queued item into output bytes and keeps adler-32 and crc-32.
// ----------------------------------------------------------------------------
module pse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [12:0]     width_i,
  input  logic [12:0]     height_i,
  input  logic            qvalid_i,
  input  pse_pkg::job_t   job_i,
  output logic            deq_o,
  output logic            ovalid_o,
  input  logic            oready_i,
  output logic [7:0]      byte_o,
  output logic            last_o,
  output logic            done_o
);
  import pse_pkg::*;

  logic [5:0]  idx_q;        // byte index within the current kind
  kind_e       kind_q;
  logic        busy_q;
  logic [25:0] rem_q;        // raw bytes still to come
  logic [15:0] blk_q;        // bytes left in the current stored block
  logic [15:0] alo_q, ahi_q;
  logic [31:0] crc_q, hcrc_q;
  logic [31:0] ilen_q;
  logic [25:0] raw_total;
  logic [25:0] blocks;
  logic [26:0] bsum;
  logic [16:0] bfold;
  logic [7:0]  pre_b, cur_b;
  logic        step, crc_en, rst_crc;
  logic [15:0] bn;
  logic [16:0] alo_s, ahi_s;
  logic [15:0] alo_n;
  kind_e       nkind;
  logic [5:0]  nidx;
  logic        endjob;
  logic [31:0] ad;

  // output register
  logic        ov_q;
  logic [7:0]  ob_q;
  logic        ol_q, od_q;
  assign ovalid_o = ov_q;
  assign byte_o   = ob_q;
  assign last_o   = ol_q;
  assign done_o   = od_q;
  assign step     = busy_q && (!ov_q || oready_i);

  // stream size, worked out at image start (one multiply)
  assign raw_total = 26'(height_i) * (26'd1 + 26'd3 * 26'(width_i));

  // stored block count, ceil(raw / 65535) from the loaded raw total
  assign bsum   = {1'b0, rem_q} + 27'd65534;
  assign bfold  = {6'd0, bsum[26:16]} + {1'b0, bsum[15:0]};
  assign blocks = {15'd0, bsum[26:16]} + 26'(bfold >= 17'd65535);

  // preamble byte for an index
  always_comb begin
    unique case (idx_q)
      6'd0: pre_b = 8'h89;  6'd1: pre_b = 8'h50;  6'd2: pre_b = 8'h4E;
      6'd3: pre_b = 8'h47;  6'd4: pre_b = 8'h0D;  6'd5: pre_b = 8'h0A;
      6'd6: pre_b = 8'h1A;  6'd7: pre_b = 8'h0A;
      6'd8, 6'd9, 6'd10: pre_b = 8'h00;  6'd11: pre_b = 8'h0D;
      6'd12: pre_b = 8'h49; 6'd13: pre_b = 8'h48; 6'd14: pre_b = 8'h44;
      6'd15: pre_b = 8'h52;
      6'd16, 6'd17: pre_b = 8'h00;
      6'd18: pre_b = {3'd0, width_i[12:8]};  6'd19: pre_b = width_i[7:0];
      6'd20, 6'd21: pre_b = 8'h00;
      6'd22: pre_b = {3'd0, height_i[12:8]}; 6'd23: pre_b = height_i[7:0];
      6'd24: pre_b = 8'h08; 6'd25: pre_b = 8'h02;
      6'd26, 6'd27, 6'd28: pre_b = 8'h00;
      6'd29: pre_b = ~hcrc_q[31:24]; 6'd30: pre_b = ~hcrc_q[23:16];
      6'd31: pre_b = ~hcrc_q[15:8];  6'd32: pre_b = ~hcrc_q[7:0];
      6'd33: pre_b = ilen_q[31:24];  6'd34: pre_b = ilen_q[23:16];
      6'd35: pre_b = ilen_q[15:8];   6'd36: pre_b = ilen_q[7:0];
      6'd37: pre_b = 8'h49; 6'd38: pre_b = 8'h44; 6'd39: pre_b = 8'h41;
      6'd40: pre_b = 8'h54; 6'd41: pre_b = 8'h78; 6'd42: pre_b = 8'h01;
      default: pre_b = 8'h00;
    endcase
  end

  assign bn = (rem_q < BLOCK_MAX) ? rem_q[15:0] : 16'hFFFF;
  assign ad = {ahi_q, alo_q};

  // current byte and next position
  always_comb begin
    cur_b   = 8'h00;
    crc_en  = 1'b0;
    rst_crc = 1'b0;
    nkind   = kind_q;
    nidx    = idx_q + 6'd1;
    endjob  = 1'b0;
    unique case (kind_q)
      K_PRE: begin
        cur_b  = pre_b;
        crc_en = (idx_q >= 6'd37);
        rst_crc = (idx_q == 6'd36);
        if (idx_q == 6'd42) begin
          nidx  = '0;
          nkind = (blk_q == '0) ? K_BHDR : (job_i.filt ? K_FILT : K_PIX);
        end
      end
      K_BHDR: begin
        crc_en = 1'b1;
        unique case (idx_q[2:0])
          3'd0: cur_b = {7'd0, rem_q <= BLOCK_MAX};
          3'd1: cur_b = bn[7:0];
          3'd2: cur_b = bn[15:8];
          3'd3: cur_b = ~bn[7:0];
          default: cur_b = ~bn[15:8];
        endcase
        if (idx_q[2:0] == 3'd4) begin
          nidx  = '0;
          nkind = (job_i.filt && !idx_q[3]) ? K_FILT : K_PIX;
        end
      end
      K_FILT, K_PIX: begin
        crc_en = 1'b1;
        cur_b  = (kind_q == K_FILT) ? 8'h00 : job_i.px;
        nidx   = '0;
        if (kind_q == K_FILT) begin
          nkind = (blk_q == 16'd1 && rem_q != 26'd1) ? K_BHDR : K_PIX;
          // a header after the filter byte counts from index 8
          if (nkind == K_BHDR) nidx = 6'd8;
        end else if (job_i.endimg) begin
          nkind = K_ADLER;
        end else begin
          endjob = 1'b1;
        end
      end
      K_ADLER: begin
        crc_en = 1'b1;
        unique case (idx_q[1:0])
          2'd0: cur_b = ad[31:24];
          2'd1: cur_b = ad[23:16];
          2'd2: cur_b = ad[15:8];
          default: cur_b = ad[7:0];
        endcase
        if (idx_q == 6'd3) begin
          nidx  = '0;
          nkind = K_DCRC;
        end
      end
      K_DCRC: begin
        unique case (idx_q[1:0])
          2'd0: cur_b = ~crc_q[31:24];
          2'd1: cur_b = ~crc_q[23:16];
          2'd2: cur_b = ~crc_q[15:8];
          default: cur_b = ~crc_q[7:0];
        endcase
        if (idx_q == 6'd3) begin
          nidx  = '0;
          nkind = K_TAIL;
        end
      end
      K_TAIL: begin
        cur_b = tail_byte(idx_q[3:0]);
        if (idx_q == 6'd11) endjob = 1'b1;
      end
      default: begin
        endjob = 1'b1;
      end
    endcase
  end

  // adler update over raw bytes
  assign alo_s = {1'b0, alo_q} + {9'd0, cur_b};
  assign alo_n = (alo_s >= ADLER_MOD) ? 16'(alo_s - ADLER_MOD) : alo_s[15:0];
  assign ahi_s = {1'b0, ahi_q} + {1'b0, alo_n};

  assign deq_o = step && endjob;

  // sequencer and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= K_PIX;
      idx_q  <= '0;
      rem_q  <= '0;
      blk_q  <= '0;
      alo_q  <= 16'd1;
      ahi_q  <= '0;
      crc_q  <= '1;
      hcrc_q <= '0;
      ilen_q <= '0;
      ov_q   <= 1'b0;
      ob_q   <= '0;
      ol_q   <= 1'b0;
      od_q   <= 1'b0;
    end else begin
      if (ov_q && oready_i && !step) ov_q <= 1'b0;
      if (!busy_q && qvalid_i && !(ov_q && !oready_i)) begin
        // load a new item
        busy_q <= 1'b1;
        idx_q  <= '0;
        if (job_i.first) begin
          kind_q <= K_PRE;
          rem_q  <= raw_total;
          blk_q  <= '0;
          alo_q  <= 16'd1;
          ahi_q  <= '0;
          // ihdr crc over the type and the width
          hcrc_q <= crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(
                      crc_byte(crc_byte(32'hFFFFFFFF, 8'h49), 8'h48), 8'h44),
                      8'h52), 8'h00), 8'h00), {3'd0, width_i[12:8]}),
                      width_i[7:0]);
        end else begin
          kind_q <= (blk_q == '0) ? K_BHDR : (job_i.filt ? K_FILT : K_PIX);
        end
      end else if (step) begin
        ov_q  <= 1'b1;
        ob_q  <= cur_b;
        ol_q  <= endjob;
        od_q  <= endjob && (kind_q == K_TAIL);
        idx_q <= nidx;
        kind_q <= nkind;
        if (endjob) busy_q <= 1'b0;
        if (crc_en) crc_q <= crc_byte(crc_q, cur_b);
        if (rst_crc) crc_q <= '1;
        // ihdr crc over height and the fixed tail, idat length in two steps
        if (kind_q == K_PRE && idx_q == 6'd0) begin
          hcrc_q <= crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(
                    crc_byte(crc_byte(crc_byte(hcrc_q, 8'h00), 8'h00),
                    {3'd0, height_i[12:8]}), height_i[7:0]), 8'h08), 8'h02),
                    8'h00), 8'h00), 8'h00);
          ilen_q <= {6'd0, blocks};
        end
        if (kind_q == K_PRE && idx_q == 6'd1) begin
          ilen_q <= (ilen_q << 2) + ilen_q + 32'(rem_q) + 32'd6;
        end
        if (kind_q == K_BHDR && idx_q[2:0] == 3'd4) blk_q <= bn;
        if (kind_q == K_FILT || kind_q == K_PIX) begin
          alo_q <= alo_n;
          ahi_q <= (ahi_s >= ADLER_MOD) ? 16'(ahi_s - ADLER_MOD) : ahi_s[15:0];
          if (rem_q != '0) rem_q <= rem_q - 26'd1;
          if (blk_q != '0) blk_q <= blk_q - 16'd1;
        end
        if (kind_q == K_TAIL && endjob) begin
          crc_q <= '1;
          blk_q <= '0;
          rem_q <= '0;
          alo_q <= 16'd1;
          ahi_q <= '0;
        end
      end
    end
  end

endmodule

@@ hdl/png_stored_rgb_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_rgb_encoder
// Pixel bytes in, complete uncompressed PNG file bytes out.
// ----------------------------------------------------------------------------
// channel   direction  handshake       payload
// pixels    in         push/full       pixel_byte_i
// png       out        pop/empty       out_byte_o, last_o, image_done_o
// config    in         cfg_we_i        cfg_idx_i, cfg_data_i
//
// The back sequencer emits one output byte per step unless the output stalls; a
// pixel byte gives one, plus one filter byte per row, five for a block header,
// 43 at image start and 20 at image end; loading each item emits no byte.
// Reset clears position and checksums; size registers reset to 1.
// A four-entry item queue lets the input run ahead while output stalls.
// ----------------------------------------------------------------------------
module png_stored_rgb_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   pixel_byte_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte_o,
  output logic                         last_o,
  output logic                         image_done_o,
  input  logic                         cfg_we_i,
  input  logic [pse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pse_pkg::CfgDataW-1:0] cfg_data_i
);
  import pse_pkg::*;

  logic [12:0] width_q, height_q, cv, wv, hv;
  logic        idle, deq, qvalid, ovalid;
  job_t        job;

  // clamp writes into range
  assign cv = (cfg_data_i == '0) ? 13'd1 : cfg_data_i;
  assign wv = (32'(cv) > MAX_WIDTH) ? 13'(MAX_WIDTH) : cv;
  assign hv = (32'(cv) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : cv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
    end else if (cfg_we_i && idle) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  width_q <= wv;
        default:    height_q <= hv;
      endcase
    end
  end

  pse_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .pixel_byte_i,
    .width_i(width_q), .height_i(height_q), .idle_o(idle),
    .deq_i(deq), .qvalid_o(qvalid), .job_o(job)
  );

  pse_back u_back (
    .clk_i, .rst_ni, .width_i(width_q), .height_i(height_q),
    .qvalid_i(qvalid), .job_i(job), .deq_o(deq),
    .ovalid_o(ovalid), .oready_i(pop), .byte_o(out_byte_o),
    .last_o, .done_o(image_done_o)
  );

  assign empty = !ovalid;

  // file end always closes an item
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && image_done_o) |-> last_o) else $error("done without last");

  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o)))
    else $error("result changed under stall");

endmodule
